FILE: src/rdle_pkg.sv
// ----------------------------------------------------------------------------
// rdle_pkg
// Types, constants and helpers shared by the datagram link engine files.
// ----------------------------------------------------------------------------
`default_nettype none
package rdle_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam logic [10:0] MAX_CHUNK = 11'd1439;
	localparam logic [15:0] HDR_LEN = 16'd12;
	localparam logic [15:0] ACK_ONLY_LEN = 16'd8;

	localparam logic [15:0] RESEND_RST = 16'd800;
	localparam logic [15:0] ACK_INT_RST = 16'd1200;
	localparam logic [5:0] WINDOW_RST = 6'd9;
	localparam logic [5:0] REEN_RST = 6'd3;

	localparam logic [2:0] CFG_RESEND = 3'd0;
	localparam logic [2:0] CFG_ACK_INT = 3'd1;
	localparam logic [2:0] CFG_WINDOW = 3'd2;
	localparam logic [2:0] CFG_REEN = 3'd3;
	localparam logic [2:0] CFG_OPEN = 3'd4;
	localparam logic [2:0] CFG_SEL = 3'd5;

	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_CHUNK = 2'd1;
	localparam logic [1:0] REQ_TIMER = 2'd2;

	localparam logic [2:0] K_ACK = 3'd0;
	localparam logic [2:0] K_DATA = 3'd1;
	localparam logic [2:0] K_DELIV = 3'd2;
	localparam logic [2:0] K_EOF = 3'd3;
	localparam logic [2:0] K_AHEAD = 3'd4;
	localparam logic [2:0] K_IDMIS = 3'd5;
	localparam logic [2:0] K_REQ = 3'd6;
	localparam logic [2:0] K_FULL = 3'd7;

	typedef struct packed {
		logic [1:0] req_type;
		logic [31:0] now_ms;
		logic [15:0] frame_len;
		logic [23:0] frame_id;
		logic signed [31:0] frame_ack;
		logic signed [31:0] frame_pck;
		logic [10:0] chunk_len;
	} in_item_t;

	typedef struct packed {
		logic [2:0] out_kind;
		logic [23:0] conn_id;
		logic signed [31:0] ack_num;
		logic signed [31:0] seq_num;
		logic [4:0] slot;
		logic [15:0] length;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] resend_delay_ms;
		logic [15:0] ack_interval_ms;
		logic [5:0] send_window;
		logic [5:0] reenable_count;
		logic stream_open;
		logic [7:0] request_selector;
	} cfg_t;

	function automatic out_item_t mk_res(input logic [2:0] kind, input logic [23:0] cid,
			input logic [31:0] ack, input logic [31:0] seq, input logic [4:0] slot,
			input logic [15:0] len);
		out_item_t r;
		r.out_kind = kind;
		r.conn_id = cid;
		r.ack_num = ack;
		r.seq_num = seq;
		r.slot = slot;
		r.length = len;
		r.last = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/rdle_ram.sv
// ----------------------------------------------------------------------------
// rdle_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rdle_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(D)-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/rdle_cfg.sv
// ----------------------------------------------------------------------------
// rdle_cfg
// Configuration register bank with index decode.
// ----------------------------------------------------------------------------
`default_nettype none
module rdle_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	output rdle_pkg::cfg_t cfg
);
	import rdle_pkg::*;

	cfg_t cfg_q;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resend_delay_ms <= RESEND_RST;
			cfg_q.ack_interval_ms <= ACK_INT_RST;
			cfg_q.send_window <= WINDOW_RST;
			cfg_q.reenable_count <= REEN_RST;
			cfg_q.stream_open <= 1'b0;
			cfg_q.request_selector <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RESEND: cfg_q.resend_delay_ms <= cfg_data;
				CFG_ACK_INT: cfg_q.ack_interval_ms <= cfg_data;
				CFG_WINDOW: cfg_q.send_window <= cfg_data[5:0];
				CFG_REEN: cfg_q.reenable_count <= cfg_data[5:0];
				CFG_OPEN: cfg_q.stream_open <= cfg_data[0];
				CFG_SEL: cfg_q.request_selector <= cfg_data[7:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/reliable_datagram_link_engine_unit.sv
// ----------------------------------------------------------------------------
// reliable_datagram_link_engine_unit
// Client side of one reliable datagram link.
//
// in_valid/in_stall/in_data carry one item: a received frame, an outgoing
// chunk or a timer fire. out_valid/out_stall/out_data return zero to two
// result items per input item; the final one has last set.
// cfg_we/cfg_idx/cfg_data write the configuration registers, idle only.
// One item at a time: in_stall is high from acceptance until the engine is
// back in idle. The re-enable sweep covers min(reenable_count, queue)
// entries and the send scan up to min(send_window, queue), each touching
// one queue entry per cycle through the entry RAMs; a data hit ends the
// scan early.
// Reset clears all link state; queue entries are only read after written.
// A stalled output holds its item; the engine waits for room, adding the
// stall cycles to the item.
// ----------------------------------------------------------------------------
`default_nettype none
module reliable_datagram_link_engine_unit #(
	parameter int QUEUE_DEPTH = rdle_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire rdle_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output rdle_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [15:0] cfg_data
);
	import rdle_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 6) ? CW : 6;
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_FREE = 3'd2;
	localparam logic [2:0] S_RX2 = 3'd3;
	localparam logic [2:0] S_RE = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_ACK = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	cfg_t cfg;
	rdle_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	logic [2:0] state_q;
	in_item_t in_q;
	logic [23:0] link_id_q;
	logic known_q;
	logic [31:0] recv_exp_q, send_base_q, nad_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic in_eof_q, out_eof_q;
	out_item_t r0_q, r1_q;
	logic r0_v_q, r1_v_q;
	logic out_v_q;
	out_item_t out_q;
	logic [LW-1:0] re_i_q, sc_i_q, sc_idx_s1;
	logic [IW-1:0] re_addr_q, sc_addr_q, sc_addr_s1;
	logic sc_v_s1;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(b);
		if (s >= DEPTH_W) s = s - DEPTH_W;
		return IW'(s);
	endfunction

	// RAM ports
	logic en_we, en_wd, en_rd;
	logic [IW-1:0] en_wa, dt_wa;
	logic dt_we;
	logic [42:0] dt_wd, dt_rd;

	rdle_ram #(.W(1), .D(QUEUE_DEPTH)) u_en_ram (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd),
		.raddr(sc_addr_q), .rdata(en_rd)
	);
	rdle_ram #(.W(43), .D(QUEUE_DEPTH)) u_dt_ram (
		.clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd),
		.raddr(sc_addr_q), .rdata(dt_rd)
	);

	logic [31:0] rd_due;
	logic [10:0] rd_len, clen;
	logic hit, full, out_free, load_out;
	logic [LW-1:0] sc_lim, re_lim, cnt_l;
	logic [IW-1:0] tail;

	assign rd_due = dt_rd[42:11];
	assign rd_len = dt_rd[10:0];
	assign hit = sc_v_s1 && en_rd && (rd_due <= in_q.now_ms);
	assign full = ({1'b0, count_q} >= DEPTH_W);
	assign clen = (in_q.chunk_len > MAX_CHUNK) ? MAX_CHUNK : in_q.chunk_len;
	assign tail = wrap_add(head_q, count_q);
	assign cnt_l = LW'(count_q);
	assign sc_lim = (LW'(cfg.send_window) < cnt_l) ? LW'(cfg.send_window) : cnt_l;
	assign re_lim = (LW'(cfg.reenable_count) < cnt_l) ? LW'(cfg.reenable_count) : cnt_l;
	assign out_free = !out_v_q || !out_stall;
	assign load_out = (state_q == S_FLUSH) && out_free && (r0_v_q || r1_v_q);

	always_comb begin
		en_we = 1'b0;
		en_wa = tail;
		en_wd = 1'b1;
		dt_we = 1'b0;
		dt_wa = tail;
		dt_wd = {in_q.now_ms, clen};
		if (state_q == S_DISP && in_q.req_type == REQ_CHUNK && !full) begin
			en_we = 1'b1;
			dt_we = 1'b1;
		end else if (state_q == S_RE && re_i_q < re_lim) begin
			en_we = 1'b1;
			en_wa = re_addr_q;
		end else if (state_q == S_SCAN && hit) begin
			en_we = 1'b1;
			en_wa = sc_addr_s1;
			en_wd = 1'b0;
			dt_we = 1'b1;
			dt_wa = sc_addr_s1;
			dt_wd = {in_q.now_ms + 32'(cfg.resend_delay_ms), rd_len};
		end
	end

	logic [31:0] ack_d;
	logic base_lt, ahead;
	logic [CW-1:0] nfree;
	assign ack_d = in_q.frame_ack - send_base_q;
	assign base_lt = $signed(send_base_q) < in_q.frame_ack;
	assign ahead = base_lt && (ack_d > 32'(count_q));
	assign nfree = !base_lt ? '0 : (ahead ? count_q : CW'(ack_d));

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			link_id_q <= '0;
			known_q <= 1'b0;
			recv_exp_q <= '0;
			send_base_q <= '0;
			nad_q <= '0;
			head_q <= '0;
			count_q <= '0;
			in_eof_q <= 1'b0;
			out_eof_q <= 1'b0;
			r0_v_q <= 1'b0;
			r1_v_q <= 1'b0;
			out_v_q <= 1'b0;
			re_i_q <= '0;
			sc_i_q <= '0;
			sc_v_s1 <= 1'b0;
		end else begin
			if (load_out) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					sc_i_q <= '0;
					sc_addr_q <= head_q;
					sc_v_s1 <= 1'b0;
					re_i_q <= '0;
					re_addr_q <= head_q;
					case (in_q.req_type)
						REQ_FRAME: begin
							if (in_q.frame_len != ACK_ONLY_LEN && in_q.frame_len < HDR_LEN) begin
								state_q <= S_IDLE;
							end else if (!known_q) begin
								link_id_q <= in_q.frame_id;
								known_q <= 1'b1;
								state_q <= S_FREE;
							end else if (link_id_q != in_q.frame_id) begin
								r0_q <= mk_res(K_IDMIS, '0, '0, '0, '0, '0);
								r0_v_q <= 1'b1;
								state_q <= S_FLUSH;
							end else begin
								state_q <= S_FREE;
							end
						end
						REQ_CHUNK: begin
							if (full) begin
								r0_q <= mk_res(K_FULL, '0, '0, '0, '0, '0);
								r0_v_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
								if (clen == '0) in_eof_q <= 1'b1;
							end
							state_q <= known_q ? S_SCAN : S_FLUSH;
						end
						REQ_TIMER: begin
							if (!known_q) begin
								r1_q <= mk_res(K_REQ, '0, '0, 32'(cfg.request_selector), '0,
									16'd1);
								r1_v_q <= 1'b1;
								nad_q <= in_q.now_ms + 32'(cfg.ack_interval_ms);
								state_q <= S_FLUSH;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_FREE: begin
					head_q <= wrap_add(head_q, nfree);
					count_q <= count_q - nfree;
					send_base_q <= send_base_q + 32'(nfree);
					if (nfree != '0) nad_q <= in_q.now_ms;
					if (ahead) begin
						r0_q <= mk_res(K_AHEAD, '0, '0, '0, '0, '0);
						r0_v_q <= 1'b1;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_RX2;
					end
				end
				S_RX2: begin
					re_addr_q <= head_q;
					sc_addr_q <= head_q;
					if (in_q.frame_len >= HDR_LEN) begin
						if (($signed(recv_exp_q) > in_q.frame_pck) ||
								(in_q.frame_pck == recv_exp_q && cfg.stream_open))
							nad_q <= in_q.now_ms;
						if (in_q.frame_pck == recv_exp_q && cfg.stream_open) begin
							if (in_q.frame_len == HDR_LEN) begin
								r0_q <= mk_res(K_EOF, '0, '0, '0, '0, '0);
								out_eof_q <= 1'b1;
							end else begin
								r0_q <= mk_res(K_DELIV, '0, '0, '0, '0,
									in_q.frame_len - HDR_LEN);
							end
							r0_v_q <= 1'b1;
							recv_exp_q <= recv_exp_q + 32'd1;
						end
					end
					state_q <= S_RE;
				end
				S_RE: begin
					if (re_i_q < re_lim) begin
						re_i_q <= re_i_q + LW'(1);
						re_addr_q <= wrap_add(re_addr_q, CW'(1));
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						r1_q <= mk_res(K_DATA, link_id_q, recv_exp_q,
							send_base_q + 32'(sc_idx_s1), 5'(sc_addr_s1), 16'(rd_len));
						r1_v_q <= 1'b1;
						sc_v_s1 <= 1'b0;
						state_q <= S_FLUSH;
					end else if (sc_i_q < sc_lim) begin
						sc_addr_s1 <= sc_addr_q;
						sc_idx_s1 <= sc_i_q;
						sc_v_s1 <= 1'b1;
						sc_i_q <= sc_i_q + LW'(1);
						sc_addr_q <= wrap_add(sc_addr_q, CW'(1));
					end else begin
						sc_v_s1 <= 1'b0;
						state_q <= S_ACK;
					end
				end
				S_ACK: begin
					if (nad_q <= in_q.now_ms) begin
						r1_q <= mk_res(K_ACK, link_id_q, recv_exp_q, '0, '0, '0);
						r1_v_q <= 1'b1;
						nad_q <= in_q.now_ms + 32'(cfg.ack_interval_ms);
					end
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (out_free) begin
						if (r0_v_q) begin
							out_q <= {r0_q[$bits(out_item_t)-1:1], !r1_v_q};
							r0_v_q <= 1'b0;
						end else if (r1_v_q) begin
							out_q <= {r1_q[$bits(out_item_t)-1:1], 1'b1};
							r1_v_q <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= DEPTH_W)
		else $error("queue count above depth");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(head_q) < DEPTH_W)
		else $error("queue head out of range");
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while busy");
	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sc_v_s1 |-> (state_q == S_SCAN))
		else $error("scan read outstanding outside scan");
endmodule
`default_nettype wire

FILE: tb/reliable_datagram_link_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// reliable_datagram_link_engine_unit_tb
// Drives frames, chunks and timer fires with random gaps and output stalls,
// predicts the results of each item with a local link model and checks every
// result field in order. Configuration changes between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none
module reliable_datagram_link_engine_unit_tb;
	import rdle_pkg::*;

	localparam int DEPTH = 32;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [15:0] cfg_data;

	reliable_datagram_link_engine_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// link model state
	cfg_t lk_cfg;
	logic [23:0] lk_id;
	logic lk_id_known;
	logic [31:0] lk_recv_exp;
	logic [31:0] lk_send_base;
	logic [31:0] lk_ack_due;
	logic [4:0] lk_head;
	int lk_count;
	logic lk_en [DEPTH];
	logic [31:0] lk_due [DEPTH];
	logic [10:0] lk_len [DEPTH];

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int errors;
	int idle_cycles;
	int hold_off;
	logic in_gap_active;
	int in_gap;
	int out_gap;
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic push_result(input logic [2:0] kind, input logic [23:0] cid,
			input logic [31:0] ack, input logic [31:0] seq, input logic [4:0] slot,
			input logic [15:0] len);
		out_item_t r;
		r.out_kind = kind;
		r.conn_id = cid;
		r.ack_num = ack;
		r.seq_num = seq;
		r.slot = slot;
		r.length = len;
		r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic run_send(input logic [31:0] now);
		int lim;
		logic [4:0] s;
		if (!lk_id_known)
			return;
		lim = (lk_cfg.send_window < lk_count) ? lk_cfg.send_window : lk_count;
		for (int i = 0; i < lim; i++) begin
			s = lk_head + 5'(i);
			if (lk_en[s] && lk_due[s] <= now) begin
				push_result(K_DATA, lk_id, lk_recv_exp, lk_send_base + 32'(i), s,
					16'(lk_len[s]));
				lk_due[s] = now + 32'(lk_cfg.resend_delay_ms);
				lk_en[s] = 1'b0;
				return;
			end
		end
		if (lk_ack_due <= now) begin
			push_result(K_ACK, lk_id, lk_recv_exp, 32'd0, 5'd0, 16'd0);
			lk_ack_due = now + 32'(lk_cfg.ack_interval_ms);
		end
	endtask

	task automatic predict_item(input in_item_t it);
		int n_prev;
		int lim;
		logic [31:0] now;
		logic [10:0] cl;
		logic [4:0] s;
		n_prev = expected_results.size();
		now = it.now_ms;
		case (it.req_type)
			REQ_FRAME: begin
				if (it.frame_len == ACK_ONLY_LEN || it.frame_len >= HDR_LEN) begin
					if (!lk_id_known) begin
						lk_id = it.frame_id;
						lk_id_known = 1'b1;
					end
					if (lk_id != it.frame_id) begin
						push_result(K_IDMIS, 24'd0, 32'd0, 32'd0, 5'd0, 16'd0);
					end else begin : frame_body
						while ($signed(lk_send_base) < it.frame_ack) begin
							if (lk_count == 0) begin
								push_result(K_AHEAD, 24'd0, 32'd0, 32'd0, 5'd0, 16'd0);
								disable frame_body;
							end
							lk_head = lk_head + 5'd1;
							lk_count--;
							lk_send_base++;
							lk_ack_due = now;
						end
						if (it.frame_len >= HDR_LEN) begin
							if ($signed(lk_recv_exp) > it.frame_pck)
								lk_ack_due = now;
							if (it.frame_pck == $signed(lk_recv_exp) && lk_cfg.stream_open) begin
								if (it.frame_len == HDR_LEN)
									push_result(K_EOF, 24'd0, 32'd0, 32'd0, 5'd0, 16'd0);
								else
									push_result(K_DELIV, 24'd0, 32'd0, 32'd0, 5'd0,
										it.frame_len - HDR_LEN);
								lk_recv_exp++;
								lk_ack_due = now;
							end
						end
						lim = (lk_cfg.reenable_count < lk_count) ? lk_cfg.reenable_count
							: lk_count;
						for (int i = 0; i < lim; i++)
							lk_en[lk_head + 5'(i)] = 1'b1;
						run_send(now);
					end
				end
			end
			REQ_CHUNK: begin
				cl = (it.chunk_len > MAX_CHUNK) ? MAX_CHUNK : it.chunk_len;
				if (lk_count >= DEPTH) begin
					push_result(K_FULL, 24'd0, 32'd0, 32'd0, 5'd0, 16'd0);
				end else begin
					s = lk_head + 5'(lk_count);
					lk_len[s] = cl;
					lk_due[s] = now;
					lk_en[s] = 1'b1;
					lk_count++;
				end
				run_send(now);
			end
			REQ_TIMER: begin
				if (!lk_id_known) begin
					push_result(K_REQ, 24'd0, 32'd0, 32'(lk_cfg.request_selector), 5'd0, 16'd1);
					lk_ack_due = now + 32'(lk_cfg.ack_interval_ms);
				end else begin
					run_send(now);
				end
			end
			default: ;
		endcase
		if (expected_results.size() > n_prev)
			expected_results[$].last = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else if (in_valid && !in_stall) begin
			predict_item(in_data);
			if (pending_items.size() > 0 && $urandom_range(0, 2) != 0) begin
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
				in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
			end
		end else if (!in_valid) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
			end else if (pending_items.size() > 0 && !in_gap_active) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result kind %0d", out_data.out_kind);
					errors++;
				end else begin : cmp
					out_item_t e;
					e = expected_results.pop_front();
					if (out_data.out_kind !== e.out_kind) begin
						$error("out_kind exp %0d got %0d", e.out_kind, out_data.out_kind);
						errors++;
					end
					if (out_data.conn_id !== e.conn_id) begin
						$error("conn_id exp %0h got %0h", e.conn_id, out_data.conn_id);
						errors++;
					end
					if (out_data.ack_num !== e.ack_num) begin
						$error("ack_num exp %0d got %0d", e.ack_num, out_data.ack_num);
						errors++;
					end
					if (out_data.seq_num !== e.seq_num) begin
						$error("seq_num exp %0d got %0d", e.seq_num, out_data.seq_num);
						errors++;
					end
					if (out_data.slot !== e.slot) begin
						$error("slot exp %0d got %0d", e.slot, out_data.slot);
						errors++;
					end
					if (out_data.length !== e.length) begin
						$error("length exp %0d got %0d", e.length, out_data.length);
						errors++;
					end
					if (out_data.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_data.last);
						errors++;
					end
				end
			end
		end
	end

	function automatic in_item_t blank_item(input logic [1:0] kind);
		in_item_t it;
		it = '0;
		it.req_type = kind;
		it.now_ms = clock_ms;
		return it;
	endfunction

	task automatic add_frame(input logic [15:0] len, input logic [23:0] id,
			input logic [31:0] ack, input logic [31:0] pck);
		in_item_t it;
		it = blank_item(REQ_FRAME);
		it.frame_len = len;
		it.frame_id = id;
		it.frame_ack = ack;
		it.frame_pck = pck;
		pending_items.push_back(it);
	endtask

	task automatic add_chunk(input logic [10:0] len);
		in_item_t it;
		it = blank_item(REQ_CHUNK);
		it.chunk_len = len;
		pending_items.push_back(it);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RESEND: lk_cfg.resend_delay_ms = val;
			CFG_ACK_INT: lk_cfg.ack_interval_ms = val;
			CFG_WINDOW: lk_cfg.send_window = val[5:0];
			CFG_REEN: lk_cfg.reenable_count = val[5:0];
			CFG_OPEN: lk_cfg.stream_open = val[0];
			default: lk_cfg.request_selector = val[7:0];
		endcase
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// mostly well-formed traffic for the given link id
	task automatic add_random(input int n, input logic [23:0] id);
		in_item_t it;
		int r;
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 1500);
			r = $urandom_range(0, 99);
			if (r < 35) begin
				add_chunk($urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 1439)));
			end else if (r < 75) begin
				it = blank_item(REQ_FRAME);
				it.frame_len = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(8, 40));
				it.frame_id = $urandom_range(0, 19) == 0 ? 24'($urandom) : id;
				it.frame_ack = 32'($urandom_range(0, 4)) - 1;
				it.frame_pck = 32'($urandom_range(0, 3)) - 1;
				if ($urandom_range(0, 19) == 0) begin
					it.frame_ack = $urandom;
					it.frame_pck = $urandom;
				end
				pending_items.push_back(it);
			end else if (r < 95) begin
				pending_items.push_back(blank_item(REQ_TIMER));
			end else begin
				it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
				it.req_type = 2'd3;
				it.now_ms = clock_ms;
				pending_items.push_back(it);
			end
		end
	endtask

	// random frames use small raw ack and packet numbers, close to the
	// link's starting numbers, with an occasional far-off value.
	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		in_gap_active = 1'b0;
		clock_ms = 32'd0;
		cfg_we = 1'b0;
		cfg_idx = CFG_RESEND;
		cfg_data = '0;
		lk_cfg = '{RESEND_RST, ACK_INT_RST, WINDOW_RST, REEN_RST, 1'b0, 8'd0};
		lk_id = '0;
		lk_id_known = 1'b0;
		lk_recv_exp = '0;
		lk_send_base = '0;
		lk_ack_due = '0;
		lk_head = '0;
		lk_count = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: request before id, then learning the id, eof and limits
		write_cfg(CFG_SEL, 16'h00ff);
		write_cfg(CFG_OPEN, 16'd1);
		pending_items.push_back(blank_item(REQ_TIMER));
		add_frame(16'd3, 24'h123456, 0, 0);
		add_frame(16'd10, 24'h123456, 0, 0);
		add_chunk(11'd0);
		add_chunk(11'h7ff);
		clock_ms = 32'd2000;
		add_frame(16'd8, 24'hffffff, 0, 0);
		add_frame(16'd8, 24'h000000, 0, 0);
		add_frame(16'd12, 24'hffffff, 0, 0);
		add_frame(16'hffff, 24'hffffff, 0, 1);
		add_frame(16'd20, 24'hffffff, 0, -5);
		add_frame(16'd8, 24'hffffff, 1, 0);
		add_frame(16'd8, 24'hffffff, 32'h7fffffff, 0);
		for (int i = 0; i < 33; i++)
			add_chunk(11'(i * 40 + 1));
		clock_ms = 32'hffff_fff0;
		pending_items.push_back(blank_item(REQ_TIMER));
		clock_ms = 32'd5;
		pending_items.push_back(blank_item(REQ_TIMER));
		wait_drained();

		write_cfg(CFG_RESEND, 16'd1);
		write_cfg(CFG_ACK_INT, 16'd1);
		write_cfg(CFG_WINDOW, 16'd0);
		write_cfg(CFG_REEN, 16'd0);
		add_random(150, 24'hffffff);
		wait_drained();

		write_cfg(CFG_RESEND, 16'hffff);
		write_cfg(CFG_ACK_INT, 16'hffff);
		write_cfg(CFG_WINDOW, 16'd32);
		write_cfg(CFG_REEN, 16'd32);
		write_cfg(CFG_OPEN, 16'd0);
		write_cfg(CFG_SEL, 16'd0);
		add_random(200, 24'hffffff);
		// long receiver hold-off while the sender keeps offering
		hold_off = 400;
		wait_drained();

		write_cfg(CFG_RESEND, 16'd800);
		write_cfg(CFG_ACK_INT, 16'd1200);
		write_cfg(CFG_WINDOW, 16'd9);
		write_cfg(CFG_REEN, 16'd3);
		write_cfg(CFG_OPEN, 16'd1);
		add_random(380, 24'hffffff);
		wait_drained();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
src/rdle_pkg.sv
src/rdle_ram.sv
src/rdle_cfg.sv
src/reliable_datagram_link_engine_unit.sv
tb/reliable_datagram_link_engine_unit_tb.sv
